// ===== rtl/core/lkst_pkg.sv =====
// ----------------------------------------------------------------------------
// lkst_pkg
// Shared types and sizes for the LRU keyed slot table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkst_pkg;

  localparam int unsigned SLOTS      = 16;
  localparam int unsigned KEY_BITS   = 64;
  localparam int unsigned IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned RANK_W     = IDX_W;
  localparam int unsigned CNT_W      = $clog2(SLOTS + 1);

  // fixed field widths of the request / result words
  localparam int unsigned KEY_FIELD_W  = 64;
  localparam int unsigned SLOT_FIELD_W = 4;

  typedef struct packed {
    logic [KEY_FIELD_W-1:0] key;
    logic                   allocate_on_miss;
  } req_t;

  typedef struct packed {
    logic                    hit;
    logic                    granted;
    logic [SLOT_FIELD_W-1:0] slot_index;
    logic                    allocated;
    logic                    replaced_valid;
  } res_t;

  // rippled along the row of cells, lowest index first
  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [RANK_W-1:0] hit_rank;
    logic              emp;
    logic [IDX_W-1:0]  emp_idx;
    logic              lru;
    logic [IDX_W-1:0]  lru_idx;
  } scan_t;

  // broadcast update for one request
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  sel;
    logic [RANK_W-1:0] old_rank;
    logic [RANK_W-1:0] top;
    logic              dec;
    logic              write;
  } upd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPD
  } state_e;

endpackage

// ===== rtl/core/lkst_cell.sv =====
// ----------------------------------------------------------------------------
// lkst_cell
// One slot: valid bit, key and recency rank. Compares the broadcast key,
// adds its vote to the priority chain and applies the broadcast update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkst_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lkst_pkg::IDX_W-1:0]    idx_i,
  input  logic [lkst_pkg::KEY_BITS-1:0] key_i,
  input  lkst_pkg::upd_t                upd_i,
  input  lkst_pkg::scan_t               scan_i,
  output lkst_pkg::scan_t               scan_o
);

  localparam logic [lkst_pkg::RANK_W-1:0] RANK_ONE = lkst_pkg::RANK_W'(1);

  logic                          valid_q, valid_d;
  logic [lkst_pkg::RANK_W-1:0]   rank_q, rank_d;
  logic [lkst_pkg::KEY_BITS-1:0] key_q;

  logic my_hit, my_emp, my_lru, sel;

  assign my_hit = valid_q && (key_q == key_i) && !scan_i.hit;
  assign my_emp = !valid_q && !scan_i.emp;
  // with a full table the ranks are distinct, so rank zero is the victim
  assign my_lru = valid_q && (rank_q == '0) && !scan_i.lru;

  always_comb begin
    scan_o          = scan_i;
    scan_o.hit      = scan_i.hit | my_hit;
    scan_o.hit_idx  = my_hit ? idx_i : scan_i.hit_idx;
    scan_o.hit_rank = my_hit ? rank_q : scan_i.hit_rank;
    scan_o.emp      = scan_i.emp | my_emp;
    scan_o.emp_idx  = my_emp ? idx_i : scan_i.emp_idx;
    scan_o.lru      = scan_i.lru | my_lru;
    scan_o.lru_idx  = my_lru ? idx_i : scan_i.lru_idx;
  end

  assign sel = upd_i.en && (upd_i.sel == idx_i);

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    if (sel) begin
      valid_d = 1'b1;
      rank_d  = upd_i.top;
    end else if (upd_i.en && upd_i.dec && valid_q && (rank_q > upd_i.old_rank)) begin
      rank_d  = rank_q - RANK_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel && upd_i.write) begin
      key_q <= key_i;
    end
  end

endmodule

// ===== rtl/core/lkst_ctrl.sv =====
// ----------------------------------------------------------------------------
// lkst_ctrl
// Request sequencer: latches the word, turns the chain outcome into a
// slot update and a result, tracks the fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkst_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  lkst_pkg::req_t                req_i,
  input  lkst_pkg::scan_t               scan_i,
  output logic [lkst_pkg::KEY_BITS-1:0] key_o,
  output lkst_pkg::upd_t                upd_o,
  output logic                          done_o,
  output lkst_pkg::res_t                res_o
);

  localparam logic [lkst_pkg::CNT_W-1:0]  CNT_ONE  = lkst_pkg::CNT_W'(1);
  localparam logic [lkst_pkg::RANK_W-1:0] RANK_TOP = lkst_pkg::RANK_W'(lkst_pkg::SLOTS - 1);

  lkst_pkg::state_e              state_q, state_d;
  logic [lkst_pkg::KEY_BITS-1:0] key_q;
  logic                          alloc_q;
  logic [lkst_pkg::CNT_W-1:0]    count_q, count_d;
  lkst_pkg::upd_t                upd_q, upd_d;
  lkst_pkg::res_t                res_q, res_d;
  logic                          accept;

  assign accept = start && !busy;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lkst_pkg::S_IDLE: if (start) state_d = lkst_pkg::S_LOOK;
      lkst_pkg::S_LOOK: state_d = lkst_pkg::S_UPD;
      lkst_pkg::S_UPD: begin
        // update lands at the end of this cycle, so a new word may enter now
        state_d = start ? lkst_pkg::S_LOOK : lkst_pkg::S_IDLE;
      end
      default: state_d = lkst_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy   = (state_q == lkst_pkg::S_LOOK);
    done_o = (state_q == lkst_pkg::S_UPD);
    res_o  = res_q;
    key_o  = key_q;
    upd_o  = upd_q;
    upd_o.en = upd_q.en && (state_q == lkst_pkg::S_UPD);
  end

  // decision from the chain outcome
  always_comb begin
    upd_d   = '0;
    res_d   = '0;
    count_d = count_q;
    if (scan_i.hit) begin
      upd_d.en       = 1'b1;
      upd_d.sel      = scan_i.hit_idx;
      upd_d.old_rank = scan_i.hit_rank;
      upd_d.top      = lkst_pkg::RANK_W'(count_q - CNT_ONE);
      upd_d.dec      = 1'b1;
      res_d.hit        = 1'b1;
      res_d.granted    = 1'b1;
      res_d.slot_index = lkst_pkg::SLOT_FIELD_W'(scan_i.hit_idx);
    end else if (alloc_q) begin
      upd_d.en    = 1'b1;
      upd_d.write = 1'b1;
      res_d.granted   = 1'b1;
      res_d.allocated = 1'b1;
      if (scan_i.emp) begin
        upd_d.sel = scan_i.emp_idx;
        upd_d.top = lkst_pkg::RANK_W'(count_q);
        count_d   = count_q + CNT_ONE;
        res_d.slot_index = lkst_pkg::SLOT_FIELD_W'(scan_i.emp_idx);
      end else begin
        upd_d.sel      = scan_i.lru_idx;
        upd_d.old_rank = '0;
        upd_d.top      = RANK_TOP;
        upd_d.dec      = 1'b1;
        res_d.replaced_valid = 1'b1;
        res_d.slot_index     = lkst_pkg::SLOT_FIELD_W'(scan_i.lru_idx);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkst_pkg::S_IDLE;
      count_q <= '0;
      upd_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == lkst_pkg::S_LOOK) begin
        count_q <= count_d;
        upd_q   <= upd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q   <= req_i.key[lkst_pkg::KEY_BITS-1:0];
      alloc_q <= req_i.allocate_on_miss;
    end
    if (state_q == lkst_pkg::S_LOOK) begin
      res_q <= res_d;
    end
  end

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o) else $error("result strobe missing after accept");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= lkst_pkg::CNT_W'(lkst_pkg::SLOTS)) else $error("fill count overflow");

  a_hit_alloc_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(res_o.hit && res_o.allocated)) else $error("hit and allocate both set");

  a_grant_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.granted |-> (res_o.hit || res_o.allocated))
    else $error("grant without hit or allocation");

  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.replaced_valid |-> res_o.allocated &&
      (count_q == lkst_pkg::CNT_W'(lkst_pkg::SLOTS)))
    else $error("eviction while table not full");

endmodule

// ===== rtl/core/lru_keyed_slot_table_core.sv =====
// ----------------------------------------------------------------------------
// lru_keyed_slot_table_core
// A word accepted at an edge passes through S_LOOK, the compare and priority
// chain through the row of slot cells, then S_UPD, which applies the rank
// update and raises the result strobe; a new word may enter during S_UPD.
// busy is high only in the compare cycle. Reset empties every slot at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_keyed_slot_table_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  lkst_pkg::req_t req_i,
  output logic           done_o,
  output lkst_pkg::res_t res_o
);

  logic [lkst_pkg::KEY_BITS-1:0] key;
  lkst_pkg::upd_t                upd;
  lkst_pkg::scan_t               chain [lkst_pkg::SLOTS+1];

  assign chain[0] = '0;

  for (genvar i = 0; i < lkst_pkg::SLOTS; i++) begin : g_cell
    lkst_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (lkst_pkg::IDX_W'(i)),
      .key_i  (key),
      .upd_i  (upd),
      .scan_i (chain[i]),
      .scan_o (chain[i+1])
    );
  end

  lkst_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .scan_i (chain[lkst_pkg::SLOTS]),
    .key_o  (key),
    .upd_o  (upd),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule

// ===== tb/sv/tb_lru_keyed_slot_table_core.sv =====
// ----------------------------------------------------------------------------
// tb_lru_keyed_slot_table_core
// Self-checking bench for the LRU keyed slot table. A scoreboard keeps its own
// copy of slot keys, valid bits and recency ranks, predicts the result word of
// every accepted request and compares each strobed result field by field.
// Stimulus: a directed fill/hit/evict sequence, then random phases drawn from
// key pools of varying size so hits, fills and evictions all occur often.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lru_keyed_slot_table_core;

  class slot_table_checker;
    logic                          slot_live [lkst_pkg::SLOTS];
    logic [lkst_pkg::KEY_BITS-1:0] slot_tag  [lkst_pkg::SLOTS];
    int unsigned                   slot_rank [lkst_pkg::SLOTS];
    lkst_pkg::res_t                awaited [$];
    int unsigned                   mismatches;

    function new();
      for (int i = 0; i < lkst_pkg::SLOTS; i++) begin
        slot_live[i] = 1'b0;
        slot_tag[i]  = '0;
        slot_rank[i] = 0;
      end
      mismatches = 0;
    endfunction

    // slot s goes to rank top; if it was live, live slots ranked above its old rank slide down
    function void promote(int unsigned s, bit was_live, int unsigned old_rank,
                          int unsigned top);
      if (was_live) begin
        for (int i = 0; i < lkst_pkg::SLOTS; i++)
          if (i != s && slot_live[i] && slot_rank[i] > old_rank)
            slot_rank[i]--;
      end
      slot_rank[s] = top;
    endfunction

    function void note_request(lkst_pkg::req_t w);
      logic [lkst_pkg::KEY_BITS-1:0] k;
      int unsigned used, s, free_s;
      bit matched, have_free;
      lkst_pkg::res_t r;
      k = w.key[lkst_pkg::KEY_BITS-1:0];
      used = 0; s = 0; free_s = 0; matched = 0; have_free = 0; r = '0;
      for (int i = 0; i < lkst_pkg::SLOTS; i++) begin
        if (slot_live[i]) begin
          used++;
          if (!matched && slot_tag[i] == k) begin
            matched = 1;
            s = i;
          end
        end else if (!have_free) begin
          have_free = 1;
          free_s = i;
        end
      end
      if (matched) begin
        promote(s, 1, slot_rank[s], used - 1);
        r.hit        = 1'b1;
        r.granted    = 1'b1;
        r.slot_index = lkst_pkg::SLOT_FIELD_W'(s);
      end else if (w.allocate_on_miss) begin
        if (have_free) begin
          s = free_s;
          slot_live[s] = 1'b1;
          slot_tag[s]  = k;
          promote(s, 0, 0, used);
        end else begin
          // full: evict lowest rank, lowest index on a tie
          s = 0;
          for (int i = 1; i < lkst_pkg::SLOTS; i++)
            if (slot_rank[i] < slot_rank[s]) s = i;
          slot_tag[s] = k;
          promote(s, 1, slot_rank[s], lkst_pkg::SLOTS - 1);
          r.replaced_valid = 1'b1;
        end
        r.granted    = 1'b1;
        r.slot_index = lkst_pkg::SLOT_FIELD_W'(s);
        r.allocated  = 1'b1;
      end
      awaited.push_back(r);
    endfunction

    function void check_result(lkst_pkg::res_t got);
      lkst_pkg::res_t want;
      if (awaited.size() == 0) begin
        $error("result word with nothing awaited: %h", got);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, got.hit);
        mismatches++;
      end
      if (got.granted !== want.granted) begin
        $error("granted: expected %0d, got %0d", want.granted, got.granted);
        mismatches++;
      end
      if (got.slot_index !== want.slot_index) begin
        $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
        mismatches++;
      end
      if (got.allocated !== want.allocated) begin
        $error("allocated: expected %0d, got %0d", want.allocated, got.allocated);
        mismatches++;
      end
      if (got.replaced_valid !== want.replaced_valid) begin
        $error("replaced_valid: expected %0d, got %0d", want.replaced_valid,
               got.replaced_valid);
        mismatches++;
      end
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  lkst_pkg::req_t req_i;
  logic           done_o;
  lkst_pkg::res_t res_o;

  slot_table_checker chk;
  int unsigned       burst_left;
  int unsigned       words_sent;

  lru_keyed_slot_table_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // pre-edge values: inputs change by NBA, so sampling here is race free
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) chk.note_request(req_i);
      if (done_o) chk.check_result(res_o);
    end
  end

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // one word; opens a new burst with a random gap when the last one ran out
  task automatic send_word(input logic [63:0] k, input logic alloc);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        start <= 1'b0;
        req_i <= {rand_key(), 1'($urandom)};
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start <= 1'b1;
    req_i <= {k, alloc};
    words_sent++;
    do @(posedge clk_i); while (busy);
  endtask

  // hold off until every awaited result has come back
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (chk.awaited.size() != 0);
    @(posedge clk_i);
    burst_left = 0;
  endtask

  initial begin
    logic [63:0] key_pool [$];
    int unsigned pool_n, phase_n;
    logic [63:0] k;

    chk        = new();
    burst_left = 0;
    words_sent = 0;
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty miss, extreme keys, fill, hit, miss on full, evictions
    send_word(64'h0, 1'b0);
    send_word(64'h0, 1'b1);
    send_word({64{1'b1}}, 1'b1);
    send_word(64'h0, 1'b0);
    send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    send_word(64'h5555_5555_5555_5555, 1'b1);
    for (int i = 1; i <= 12; i++) send_word(64'(i) << (i * 4), 1'b1);
    send_word(64'hDEAD_BEEF_0000_0001, 1'b0);
    send_word(64'h8000_0000_0000_0000, 1'b1);
    send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    send_word(64'h0, 1'b1);
    send_word(64'h0000_0000_0000_0001, 1'b1);
    send_word({64{1'b1}}, 1'b0);
    drain();

    // random phases: pool size sets the hit / evict mix
    while (words_sent < 1900) begin
      pool_n  = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 6)
                                            : $urandom_range(8, 40);
      phase_n = $urandom_range(60, 200);
      if (phase_n > 1900 - words_sent) phase_n = 1900 - words_sent;
      key_pool.delete();
      for (int i = 0; i < pool_n; i++) begin
        case ($urandom_range(0, 15))
          0:       key_pool.push_back(64'h0);
          1:       key_pool.push_back({64{1'b1}});
          default: key_pool.push_back(rand_key());
        endcase
      end
      for (int i = 0; i < phase_n; i++) begin
        if ($urandom_range(0, 9) == 0) k = rand_key();
        else k = key_pool[$urandom_range(0, pool_n - 1)];
        send_word(k, ($urandom_range(0, 3) != 0));
      end
      if ($urandom_range(0, 2) == 0) drain();
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (chk.mismatches == 0 && chk.awaited.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lkst_pkg.sv
rtl/core/lkst_cell.sv
rtl/core/lkst_ctrl.sv
rtl/core/lru_keyed_slot_table_core.sv
tb/sv/tb_lru_keyed_slot_table_core.sv
